// ===== rtl/crsf_pkg.sv =====
// ----------------------------------------------------------------------------
// crsf_pkg
// shared types, constants and the crc-8 byte step for the rc frame parser
// ----------------------------------------------------------------------------
package crsf_pkg;

	// register indexes of the configuration port
	typedef enum logic [0:0] {
		REG_SYNC_BYTE     = 1'b0,
		REG_RC_FRAME_TYPE = 1'b1
	} reg_idx_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_CHANNEL = 2'd0,
		KIND_LEN_ERR = 2'd1,
		KIND_CRC_ERR = 2'd2
	} kind_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_RX,
		ST_FETCH,
		ST_LOAD,
		ST_CONV,
		ST_WAIT
	} state_t;

	localparam logic [7:0]  SYNC_RESET    = 8'hC8;
	localparam logic [7:0]  RC_TYPE_RESET = 8'h16;
	localparam logic [7:0]  CRC_POLY      = 8'hD5;
	localparam int          RC_PAYLOAD_LEN = 22;
	localparam int          PAYLOAD_BASE  = 3;
	localparam int          NUM_CH        = 16;
	localparam int          CH_BITS       = 11;

	// pulse conversion: 1000 + floor((raw - 172) * 1000 / 1639)
	localparam logic [10:0] RAW_LOW       = 11'd172;
	localparam logic [10:0] RAW_HIGH      = 11'd1811;
	localparam logic [10:0] PULSE_MIN     = 11'd1000;
	localparam logic [10:0] PULSE_MAX     = 11'd2000;
	// ceil(2^22 * 1000 / 1639), exact floor for every 11-bit difference
	localparam logic [21:0] RECIP_MUL     = 22'd2559063;
	localparam int          RECIP_SHIFT   = 22;

	// one byte through the msb-first crc-8 register
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/crsf_rc_frame_parser_unit.sv =====
// ----------------------------------------------------------------------------
// crsf_rc_frame_parser_unit
// rc channel frame parser: sync hunt, length check, crc-8 (0xd5), unpacking
// of sixteen 11-bit channels into microsecond pulse widths
// ----------------------------------------------------------------------------
//
//  channel  beat                         handshake
//  -------  ---------------------------  -------------------------------
//  in       rx_byte                      in_valid / in_stall
//  out      kind channel pulse_us last   out_valid / out_stall
//           good_frames bad_frames
//           bytes_seen
//  cfg      cfg_idx cfg_wdata            cfg_we, no wait, no read-back
//
//  one byte a cycle while receiving and not stalled; the crc runs a byte per cycle alongside
//  after a good rc frame the payload is read back from the frame ram through
//  its single read port, 22 reads for 16 channels, and each channel passes
//  the one-deep converter, while input is stalled
//  error beats leave in the cycle after the offending byte
//  no clearing pass after reset; the frame ram is only read where written
//  a full, stalled output register stalls input and the unpack sequencer
//
module crsf_rc_frame_parser_unit #(
	parameter int FRAME_MAX = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [7:0]  cfg_wdata,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	// results
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [4:0]  channel,
	output logic [10:0] pulse_us,
	output logic        last,
	output logic [31:0] good_frames,
	output logic [31:0] bad_frames,
	output logic [31:0] bytes_seen
);

	localparam int AW = $clog2(FRAME_MAX);
	localparam int FW = $clog2(FRAME_MAX + 1);

	crsf_pkg::state_t state_q, state_n;

	// configuration registers
	logic [7:0]  sync_q;
	logic [7:0]  rc_type_q;

	// frame receive state
	logic          in_frame_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] fill_n;
	logic [7:0]    len_q;
	logic [7:0]    type_q;
	logic [7:0]    crc_q;

	// counters, and their values after this cycle
	logic [31:0] good_q, bad_q, bytes_q;
	logic [31:0] good_n, bad_n, bytes_n;

	// unpack sequencer
	logic [4:0]  idx_q;
	logic [4:0]  nbits_q;
	logic [17:0] acc_q;
	logic [4:0]  ch_q;

	// output register
	logic        out_valid_q;
	logic        out_free;
	logic [1:0]  kind_q;
	logic [4:0]  channel_q;
	logic [10:0] pulse_q;
	logic        last_q;
	logic [31:0] good_out_q, bad_out_q, bytes_out_q;

	// byte decode
	logic       in_acc;
	logic       hit_sync;
	logic       at_len;
	logic       at_end;
	logic       len_bad;
	logic       crc_ok;
	logic       rc_good;
	logic       err_load;
	logic       unpack_start;
	crsf_pkg::kind_t err_kind;

	// ram and converter hookup
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;
	logic          conv_go;
	logic          conv_take;
	logic          conv_busy;
	logic [10:0]   conv_pulse;

	// ------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q    <= crsf_pkg::SYNC_RESET;
			rc_type_q <= crsf_pkg::RC_TYPE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				crsf_pkg::REG_SYNC_BYTE:     sync_q    <= cfg_wdata;
				crsf_pkg::REG_RC_FRAME_TYPE: rc_type_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// byte decode
	// ------------------------------------------------------------------
	assign out_free = !out_valid_q || !out_stall;
	assign in_acc   = in_valid && !in_stall;
	assign hit_sync = (rx_byte == sync_q);
	assign fill_n   = fill_q + FW'(1);
	// second byte of the frame carries the length
	assign at_len   = (fill_q == FW'(1));
	// no wrap: 254 and 255 fail as well
	assign len_bad  = (rx_byte < 8'd2) || ((10'(rx_byte) + 10'd2) > 10'(FRAME_MAX));
	assign at_end   = (10'(fill_n) == (10'(len_q) + 10'd2));
	// last byte of the frame is the crc over type and payload
	assign crc_ok   = (rx_byte == crc_q);
	assign rc_good  = (type_q == rc_type_q) &&
	                  (len_q == 8'(crsf_pkg::RC_PAYLOAD_LEN + 2));

	assign err_load = in_acc && in_frame_q &&
	                  ((at_len && len_bad) || (!at_len && at_end && !crc_ok));
	assign err_kind = at_len ? crsf_pkg::KIND_LEN_ERR : crsf_pkg::KIND_CRC_ERR;
	assign unpack_start = in_acc && in_frame_q && !at_len && at_end && crc_ok && rc_good;

	assign bytes_n = in_acc ? bytes_q + 32'd1 : bytes_q;
	assign bad_n   = err_load ? bad_q + 32'd1 : bad_q;
	assign good_n  = unpack_start ? good_q + 32'd1 : good_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			fill_q     <= '0;
			good_q     <= '0;
			bad_q      <= '0;
			bytes_q    <= '0;
		end else begin
			good_q  <= good_n;
			bad_q   <= bad_n;
			bytes_q <= bytes_n;
			if (in_acc) begin
				if (!in_frame_q) begin
					if (hit_sync) begin
						in_frame_q <= 1'b1;
						fill_q     <= FW'(1);
					end
				end else if (at_len) begin
					if (len_bad) begin
						in_frame_q <= 1'b0;
						fill_q     <= '0;
					end else begin
						fill_q <= fill_n;
					end
				end else if (!at_end) begin
					fill_q <= fill_n;
				end else begin
					in_frame_q <= 1'b0;
					fill_q     <= '0;
				end
			end
		end
	end

	// length, type and running crc
	always_ff @(posedge clk) begin
		if (in_acc && in_frame_q) begin
			if (at_len) begin
				len_q <= rx_byte;
				crc_q <= '0;
			end else if (!at_end) begin
				crc_q <= crsf_pkg::crc8_step(crc_q, rx_byte);
				if (fill_q == FW'(2)) begin
					type_q <= rx_byte;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// frame ram
	// ------------------------------------------------------------------
	assign ram_we    = in_acc && (in_frame_q || hit_sync);
	assign ram_waddr = in_frame_q ? fill_q[AW-1:0] : '0;
	assign ram_raddr = AW'(idx_q + 5'(crsf_pkg::PAYLOAD_BASE));

	crsf_ram #(
		.WIDTH (8),
		.DEPTH (FRAME_MAX)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (rx_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// unpack sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			crsf_pkg::ST_RX: begin
				if (unpack_start) state_n = crsf_pkg::ST_FETCH;
			end
			crsf_pkg::ST_FETCH: state_n = crsf_pkg::ST_LOAD;
			crsf_pkg::ST_LOAD: begin
				// eight more bits arrive this cycle
				state_n = (nbits_q >= 5'd3) ? crsf_pkg::ST_CONV : crsf_pkg::ST_FETCH;
			end
			crsf_pkg::ST_CONV: state_n = crsf_pkg::ST_WAIT;
			crsf_pkg::ST_WAIT: begin
				if (conv_take) begin
					priority if (ch_q == 5'(crsf_pkg::NUM_CH)) state_n = crsf_pkg::ST_RX;
					else if (nbits_q >= 5'(crsf_pkg::CH_BITS)) state_n = crsf_pkg::ST_CONV;
					else state_n = crsf_pkg::ST_FETCH;
				end
			end
			default: state_n = crsf_pkg::ST_RX;
		endcase
	end

	always_comb begin
		in_stall  = !((state_q == crsf_pkg::ST_RX) && out_free);
		ram_re    = (state_q == crsf_pkg::ST_FETCH);
		conv_go   = (state_q == crsf_pkg::ST_CONV);
		conv_take = (state_q == crsf_pkg::ST_WAIT) && conv_busy && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crsf_pkg::ST_RX;
			idx_q   <= '0;
			nbits_q <= '0;
			ch_q    <= '0;
		end else begin
			state_q <= state_n;
			if (unpack_start) begin
				idx_q   <= '0;
				nbits_q <= '0;
				ch_q    <= '0;
			end else if (state_q == crsf_pkg::ST_FETCH) begin
				idx_q <= idx_q + 5'd1;
			end else if (state_q == crsf_pkg::ST_LOAD) begin
				nbits_q <= nbits_q + 5'd8;
			end else if (conv_go) begin
				nbits_q <= nbits_q - 5'(crsf_pkg::CH_BITS);
				ch_q    <= ch_q + 5'd1;
			end
		end
	end

	// lsb-first bit buffer
	always_ff @(posedge clk) begin
		if (unpack_start) begin
			acc_q <= '0;
		end else if (state_q == crsf_pkg::ST_LOAD) begin
			acc_q <= acc_q | (18'(ram_rdata) << nbits_q);
		end else if (conv_go) begin
			acc_q <= acc_q >> crsf_pkg::CH_BITS;
		end
	end

	crsf_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (conv_go),
		.raw    (acc_q[10:0]),
		.take   (conv_take),
		.busy   (conv_busy),
		.pulse  (conv_pulse)
	);

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (err_load || conv_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// ch_q already counts the channel on its way, so it is the 1-based number
	always_ff @(posedge clk) begin
		if (err_load) begin
			kind_q    <= err_kind;
			channel_q <= '0;
			pulse_q   <= '0;
			last_q    <= 1'b1;
		end else if (conv_take) begin
			kind_q    <= crsf_pkg::KIND_CHANNEL;
			channel_q <= ch_q;
			pulse_q   <= conv_pulse;
			last_q    <= (ch_q == 5'(crsf_pkg::NUM_CH));
		end
		if (err_load || conv_take) begin
			good_out_q  <= good_n;
			bad_out_q   <= bad_n;
			bytes_out_q <= bytes_n;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign channel     = channel_q;
	assign pulse_us    = pulse_q;
	assign last        = last_q;
	assign good_frames = good_out_q;
	assign bad_frames  = bad_out_q;
	assign bytes_seen  = bytes_out_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
`ifndef SYNTH
	// a frame never runs past the end of the store
	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (32'(fill_q) < FRAME_MAX))
		else $error("fill index beyond frame store");

	// the last channel takes exactly the remaining eleven bits
	a_bits_used_up: assert property (@(posedge clk) disable iff (!arst_n)
		(conv_go && ch_q == 5'(crsf_pkg::NUM_CH - 1)) |-> (nbits_q == 5'(crsf_pkg::CH_BITS)))
		else $error("payload bits left over after last channel");

	// payload reads stay inside the 22 payload bytes
	a_read_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (idx_q < 5'(crsf_pkg::RC_PAYLOAD_LEN)))
		else $error("payload read beyond rc payload");

	// the converter only holds a value while the sequencer waits for it
	a_conv_owned: assert property (@(posedge clk) disable iff (!arst_n)
		conv_busy |-> (state_q == crsf_pkg::ST_WAIT))
		else $error("converter busy outside wait state");

	// no new byte is taken while a frame is being unpacked
	a_no_rx_in_unpack: assert property (@(posedge clk) disable iff (!arst_n)
		unpack_start |=> (state_q == crsf_pkg::ST_FETCH && !in_frame_q))
		else $error("unpack did not start cleanly");
`endif

endmodule

// ===== rtl/crsf_ram.sv =====
// ----------------------------------------------------------------------------
// crsf_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module crsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/crsf_conv.sv =====
// ----------------------------------------------------------------------------
// crsf_conv
// raw 11-bit channel to pulse width in microseconds, reciprocal multiply
// ----------------------------------------------------------------------------
module crsf_conv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [10:0] raw,
	input  logic        take,
	output logic        busy,
	output logic [10:0] pulse
);

	logic        valid_s1;
	logic        lo_s1;
	logic        hi_s1;
	logic [10:0] q_s1;
	logic [10:0] diff;
	logic [32:0] prod;

	// difference is only used when raw lies inside the span
	assign diff = raw - crsf_pkg::RAW_LOW;
	assign prod = 33'(diff) * 33'(crsf_pkg::RECIP_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (go) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			lo_s1 <= (raw < crsf_pkg::RAW_LOW);
			hi_s1 <= (raw > crsf_pkg::RAW_HIGH);
			q_s1  <= prod[crsf_pkg::RECIP_SHIFT +: 11];
		end
	end

	assign busy  = valid_s1;
	assign pulse = lo_s1 ? crsf_pkg::PULSE_MIN :
	               hi_s1 ? crsf_pkg::PULSE_MAX :
	               11'(crsf_pkg::PULSE_MIN + q_s1);

endmodule
